/* sv/u2a_pkg.sv */
// ----------------------------------------------------------------------------
// u2a_pkg: shared types and constants for the unsigned-to-ASCII digit unit
// Holds the request record, digit limits, ASCII anchors and the digit map.
// ----------------------------------------------------------------------------
package u2a_pkg;

  // Largest number of digits a 32-bit value can produce (base ten)
  localparam int unsigned DigitsMax = 10;
  localparam int unsigned DigitIdxW = $clog2(DigitsMax);

  // ASCII anchors
  localparam logic [6:0] AsciiZero = 7'h30;
  localparam logic [6:0] AsciiUpA  = 7'h41;

  // Reciprocal of ten: floor(v / 10) == (v * Recip10) >> Recip10Shift for 32-bit v
  localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;

  // One request as it waits between the front and back parts
  typedef struct packed {
    logic [31:0] value;
    logic        hex_mode;
  } u2a_req_t;

  // Map a digit 0..15 onto its ASCII character
  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] res;
    if (d >= 4'd10) begin
      res = AsciiUpA + 7'(d - 4'd10);
    end else begin
      res = AsciiZero + 7'(d);
    end
    return res;
  endfunction

endpackage

/* sv/u2a_front.sv */
// ----------------------------------------------------------------------------
// u2a_front: request intake and two-entry queue
// Accepts requests from the input channel and holds them for the back part.
// ----------------------------------------------------------------------------
module u2a_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       value_i,
  input  logic              hex_mode_i,
  output logic              req_valid_o,
  output u2a_pkg::u2a_req_t req_o,
  input  logic              req_pop_i
);
  import u2a_pkg::*;

  u2a_req_t   ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  logic       pop;
  u2a_req_t   new_req;

  // Build the request record from the port fields
  always_comb begin
    new_req.value    = value_i;
    new_req.hex_mode = hex_mode_i;
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = req_pop_i && req_valid_o;
  assign req_valid_o = (fill_q != 2'd0);
  assign req_o       = ent_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_req;
    end
  end

endmodule

/* sv/u2a_back.sv */
// ----------------------------------------------------------------------------
// u2a_back: digit conversion and character emission
// Splits the value into digits least significant first, one per cycle, into a
// small digit store, then plays them back most significant first.
// ----------------------------------------------------------------------------
module u2a_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  u2a_pkg::u2a_req_t req_i,
  output logic              req_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        ascii_char_o,
  output logic              last_char_o
);
  import u2a_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]           state_q, state_d;
  logic                 first_q, first_d;
  logic                 pend_q, pend_d;
  logic [DigitIdxW-1:0] cnt_q, cnt_d;
  logic [DigitIdxW-1:0] idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;

  logic [31:0]          cur_q;
  logic [31:0]          prv_q;
  logic                 hex_q;
  logic [3:0]           dig_q [DigitsMax];
  logic [6:0]           char_q;
  logic                 last_q;

  logic [63:0]          prod;
  logic [31:0]          quot;
  logic [3:0]           digit;
  logic                 split;
  logic                 out_free;
  logic                 load_out;
  logic                 wr_dig;
  logic                 do_split;

  // Quotient of the current value by the base
  assign prod  = 64'(cur_q) * 64'(Recip10);
  assign quot  = hex_q ? (cur_q >> 4) : 32'(prod[63:Recip10Shift]);
  assign split = first_q || (cur_q != 32'd0);

  // Remainder: previous value less base times its quotient (low nibble is exact)
  assign digit = hex_q ? prv_q[3:0]
                       : prv_q[3:0] - {cur_q[0], 3'b000} - {cur_q[2:0], 1'b0};

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequence the request through conversion and emission
  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    req_pop_o   = 1'b0;
    load_out    = 1'b0;
    wr_dig      = 1'b0;
    do_split    = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          state_d   = StConv;
          first_d   = 1'b1;
          pend_d    = 1'b0;
          cnt_d     = '0;
        end
      end
      StConv: begin
        if (pend_q) begin
          wr_dig = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
        if (split) begin
          do_split = 1'b1;
          first_d  = 1'b0;
          pend_d   = 1'b1;
        end else begin
          pend_d  = 1'b0;
          idx_d   = cnt_q;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          if (idx_q == '0) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      first_q     <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the value being divided and the digit store
  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      cur_q <= req_i.value;
      hex_q <= req_i.hex_mode;
    end else if (do_split) begin
      prv_q <= cur_q;
      cur_q <= quot;
    end
    if (wr_dig) begin
      dig_q[cnt_q] <= digit;
    end
    if (load_out) begin
      char_q <= digit_to_ascii(dig_q[idx_q]);
      last_q <= (idx_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

endmodule

/* sv/unsigned_to_ascii_digits_unit.sv */
// ----------------------------------------------------------------------------
// unsigned_to_ascii_digits_unit: 32-bit unsigned to ASCII digit stream
// Emits the decimal or upper-case hexadecimal digits of a value, most
// significant first, without leading zeros, one character per output transfer.
// ----------------------------------------------------------------------------
// A request occupies the converter while it is picked up, while its digits are
// split off through the divide-by-ten reciprocal multiplier (a shift in hex
// mode), and while they are played back out of the digit store, one character
// a cycle when the output is not stalled.
// A two-entry queue in front takes new requests while the converter is busy.
// Zero gives a single '0'; the final character has last_char_o set.
module unsigned_to_ascii_digits_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_i,
  input  logic        hex_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  ascii_char_o,
  output logic        last_char_o
);
  import u2a_pkg::*;

  logic     req_valid;
  u2a_req_t req;
  logic     req_pop;

  u2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .hex_mode_i  (hex_mode_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  u2a_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid),
    .req_i        (req),
    .req_pop_o    (req_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

endmodule

/* sv/u2a_checker.sv */
// ----------------------------------------------------------------------------
// u2a_checker: port-level checks for the digit unit
// Watches the output channel for handshake and character-stream rules.
// ----------------------------------------------------------------------------
module u2a_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] ascii_char_o,
  input logic       last_char_o
);
  import u2a_pkg::*;

  // Track whether the next character opens a new number
  logic first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      first_q <= last_char_o;
    end
  end

  // Hold a stalled result
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ascii_char_o)
      && $stable(last_char_o))
    else $error("stalled result changed");

  // Emit only digit characters
  a_char_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ascii_char_o >= AsciiZero && ascii_char_o <= 7'h39)
      || (ascii_char_o >= AsciiUpA && ascii_char_o <= 7'h46))
    else $error("result is not a digit character");

  // Drop leading zeros: a number of several digits never opens with '0'
  a_no_lead_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_q && !last_char_o |-> ascii_char_o != AsciiZero)
    else $error("leading zero emitted");

  // Nothing shows on the output straight after reset
  a_reset_quiet : assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid straight after reset");

endmodule

bind unsigned_to_ascii_digits_unit u2a_checker u_u2a_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .ascii_char_o (ascii_char_o),
  .last_char_o  (last_char_o)
);
